@@ src/uidw_pkg.sv @@
// Package with constants and types shared by the descriptor walker modules.
`timescale 1ns / 1ps

package uidw_pkg;

    localparam int MAX_INTERFACES = 16;
    localparam int BUFFER_BYTES   = 256;

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int TOT_W = (POS_W > 8) ? POS_W : 8;
    localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

    localparam logic [7:0] IFACE_TYPE      = 8'd4;
    localparam logic [7:0] FALLBACK_NUMBER = 8'hFF;
    localparam logic [7:0] MIN_IFACE_LEN   = 8'd8;

    localparam logic [1:0] REG_DEVICE_CLASS    = 2'd0;
    localparam logic [1:0] REG_DEVICE_SUBCLASS = 2'd1;
    localparam logic [1:0] REG_DEVICE_PROTOCOL = 2'd2;

    localparam int IDX_W      = 2;
    localparam int CFG_W      = 8;
    localparam int M_TDATA_W  = 40;
    localparam int COUNT_W    = 5;
    localparam int COUNT_LSB  = 32;

    typedef struct packed {
        logic [7:0] dev_class;
        logic [7:0] dev_subclass;
        logic [7:0] dev_protocol;
    } dev_codes_t;

    typedef struct packed {
        logic               record_valid;
        logic [7:0]         number;
        logic [7:0]         iclass;
        logic [7:0]         subclass;
        logic [7:0]         protocol;
        logic               end_of_list;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

@@ src/uidw_walk.sv @@
// Descriptor walk state and per-byte decode, one transfer per enabled cycle.
`timescale 1ns / 1ps

module uidw_walk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                action,
    input  logic [7:0]          data_byte,
    input  uidw_pkg::dev_codes_t dev_codes,
    output logic                has_result,
    output uidw_pkg::result_t   result
);
    import uidw_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [7:0]       off_reg, off_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       dtype_reg, dtype_next;
    logic             stopped_reg, stopped_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic [7:0]       cap_reg [5];
    logic [7:0]       cap_next [5];

    logic [15:0]      full_len;
    logic [TOT_W-1:0] start;
    logic [8:0]       off_inc;

    always_comb begin
        pos_next     = pos_reg;
        total_next   = total_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        dtype_next   = dtype_reg;
        stopped_next = stopped_reg;
        found_next   = found_reg;
        for (int i = 0; i < 5; i++) begin
            cap_next[i] = cap_reg[i];
        end
        has_result   = 1'b0;
        result       = '0;
        full_len     = {data_byte, total_reg[7:0]};
        start        = TOT_W'(pos_reg) - TOT_W'(off_reg);
        off_inc      = 9'd0;

        if (action) begin
            has_result         = 1'b1;
            result.end_of_list = 1'b1;
            if (found_reg != '0) begin
                result.count = COUNT_W'(found_reg);
            end else begin
                result.record_valid = 1'b1;
                result.number       = FALLBACK_NUMBER;
                result.iclass       = dev_codes.dev_class;
                result.subclass     = dev_codes.dev_subclass;
                result.protocol     = dev_codes.dev_protocol;
                result.count        = COUNT_W'(1);
            end
            pos_next     = '0;
            total_next   = TOT_W'(BUFFER_BYTES);
            off_next     = '0;
            len_next     = '0;
            dtype_next   = '0;
            stopped_next = 1'b0;
            found_next   = '0;
            for (int i = 0; i < 5; i++) begin
                cap_next[i] = '0;
            end
        end else if (pos_reg < POS_W'(BUFFER_BYTES)) begin
            if (pos_reg == POS_W'(2)) begin
                total_next = TOT_W'(data_byte);
            end else if (pos_reg == POS_W'(3)) begin
                if (full_len > 16'(BUFFER_BYTES)) begin
                    total_next = TOT_W'(BUFFER_BYTES);
                end else begin
                    total_next = TOT_W'(full_len);
                end
            end
            if (!stopped_reg) begin
                case (off_reg)
                    8'd0: begin
                        len_next   = data_byte;
                        dtype_next = '0;
                        if (data_byte == 8'd0) begin
                            stopped_next = 1'b1;
                        end
                    end
                    8'd1: dtype_next  = data_byte;
                    8'd2: cap_next[0] = data_byte;
                    8'd3: cap_next[1] = data_byte;
                    8'd5: cap_next[2] = data_byte;
                    8'd6: cap_next[3] = data_byte;
                    8'd7: begin
                        cap_next[4] = data_byte;
                        if (dtype_reg == IFACE_TYPE && len_reg >= MIN_IFACE_LEN &&
                            cap_reg[1] == 8'd0 && start < total_next &&
                            found_reg < CNT_W'(MAX_INTERFACES)) begin
                            found_next          = found_reg + CNT_W'(1);
                            has_result          = 1'b1;
                            result.record_valid = 1'b1;
                            result.number       = cap_reg[0];
                            result.iclass       = cap_reg[2];
                            result.subclass     = cap_reg[3];
                            result.protocol     = data_byte;
                            result.count        = COUNT_W'(found_next);
                        end
                    end
                    default: ;
                endcase
                if (!stopped_next) begin
                    off_inc = {1'b0, off_reg} + 9'd1;
                    if (off_inc >= {1'b0, len_next}) begin
                        off_next = '0;
                    end else begin
                        off_next = off_inc[7:0];
                    end
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            total_reg   <= TOT_W'(BUFFER_BYTES);
            off_reg     <= '0;
            len_reg     <= '0;
            dtype_reg   <= '0;
            stopped_reg <= 1'b0;
            found_reg   <= '0;
            for (int i = 0; i < 5; i++) begin
                cap_reg[i] <= '0;
            end
        end else if (step_en) begin
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            dtype_reg   <= dtype_next;
            stopped_reg <= stopped_next;
            found_reg   <= found_next;
            for (int i = 0; i < 5; i++) begin
                cap_reg[i] <= cap_next[i];
            end
        end
    end

endmodule

@@ src/usb_interface_descriptor_walker.sv @@
// Top level of the USB configuration descriptor interface walker.
// Takes one descriptor byte or finish transfer per clock; each is decoded
// combinationally against the walk state and any record lands in one output
// register, so throughput is one item per cycle while m_tready stays high.
// The record of an accepted input is shown in the next cycle. s_tready is high
// whenever the output register is empty or is being drained in that cycle; the
// only thing that slows the input is backpressure on the output. Device codes
// must be written via the cfg port only while idle; the block does not check.
`timescale 1ns / 1ps

module usb_interface_descriptor_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] number, [15:8] class, [23:16] subclass, [31:24] protocol,
    // [36:32] interface_count, [39:37] zero
    output logic [uidw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // [0] record_valid
    output logic                           m_tlast,   // end_of_list
    input  logic                           cfg_wr_en,
    input  logic [uidw_pkg::IDX_W-1:0]     cfg_index,
    input  logic [uidw_pkg::CFG_W-1:0]     cfg_wr_data
);
    import uidw_pkg::*;

    dev_codes_t dev_reg;
    logic       in_fire;
    logic       has_result;
    result_t    result;
    logic       out_valid_reg;
    result_t    out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    uidw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (in_fire),
        .action     (s_tuser),
        .data_byte  (s_tdata),
        .dev_codes  (dev_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEVICE_CLASS:    dev_reg.dev_class    <= cfg_wr_data;
                REG_DEVICE_SUBCLASS: dev_reg.dev_subclass <= cfg_wr_data;
                REG_DEVICE_PROTOCOL: dev_reg.dev_protocol <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= in_fire && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && has_result) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.record_valid;
    assign m_tlast  = out_reg.end_of_list;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.protocol, out_reg.subclass,
                       out_reg.iclass, out_reg.number};

endmodule

@@ src/uidw_checker.sv @@
// Port-level checker for the descriptor walker and its bind.
`timescale 1ns / 1ps

module uidw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [uidw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import uidw_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_byte_is_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser &&
            m_tdata[COUNT_LSB+COUNT_W-1:COUNT_LSB] != '0)
        else $error("byte transfer result without record");

    a_fallback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser |-> m_tdata[7:0] == FALLBACK_NUMBER &&
            m_tdata[COUNT_LSB+COUNT_W-1:COUNT_LSB] == COUNT_W'(1))
        else $error("bad fallback record");

    a_finish_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("end of list carries interface fields");

endmodule

bind usb_interface_descriptor_walker uidw_checker u_uidw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/usb_interface_descriptor_walker_tb.sv @@
// Testbench for the descriptor walker: directed table, then random descriptor frames.
`timescale 1ns / 1ps

module usb_interface_descriptor_walker_tb;
    import uidw_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 45;
    localparam int NUM_PHASES   = 5;
    localparam int NUM_DIRECTED = 20;
    localparam logic [7:0] ENDPOINT_TYPE = 8'h05;
    localparam logic [7:0] CONFIG_TYPE   = 8'h02;
    localparam logic [7:0] CLASS_TYPE    = 8'h21;

    typedef struct packed {
        bit         act;
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } stim_row_t;

    localparam result_t FALLBACK_RESET = '{1'b1, FALLBACK_NUMBER, 8'h00, 8'h00, 8'h00,
                                           1'b1, 5'd1};
    localparam result_t RECORD_ALL_ONES = '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 5'd1};
    localparam result_t DONE_ONE = '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 5'd1};
    localparam result_t NO_RESULT = '0;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = 8'h00;   // [7:0] data_byte
    logic                  s_tuser     = 1'b0;    // [0] action
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // [7:0] number, [15:8] class, [23:16] subclass, [31:24] protocol,
    // [36:32] interface_count, [39:37] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;               // [0] record_valid
    logic                  m_tlast;               // end_of_list
    logic                  cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0]      cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    bit                    row_typed   = 1'b0;
    result_t               row_want    = '0;

    bit                    hold_rx     = 1'b0;
    bit                    quiet       = 1'b0;
    int                    errors      = 0;
    int                    cycle_count = 0;
    int                    sent_items  = 0;

    result_t               records_due [$];
    logic [7:0]            frame_q [$];

    logic [8:0]            walk_pos;
    logic [8:0]            walk_total;
    logic [7:0]            walk_off;
    logic [7:0]            walk_len;
    logic [7:0]            walk_type;
    bit                    walk_stopped;
    logic [4:0]            walk_found;
    logic [7:0]            walk_cap [5];
    dev_codes_t            dev_codes = '0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b1, 8'hA5, 1'b1, FALLBACK_RESET},
        '{1'b0, 8'h08, 1'b0, NO_RESULT},
        '{1'b0, 8'h04, 1'b0, NO_RESULT},
        '{1'b0, 8'hFF, 1'b0, NO_RESULT},
        '{1'b0, 8'h00, 1'b0, NO_RESULT},
        '{1'b0, 8'h00, 1'b0, NO_RESULT},
        '{1'b0, 8'hFF, 1'b0, NO_RESULT},
        '{1'b0, 8'hFF, 1'b0, NO_RESULT},
        '{1'b0, 8'hFF, 1'b1, RECORD_ALL_ONES},
        '{1'b0, 8'h07, 1'b0, NO_RESULT},
        '{1'b0, 8'h04, 1'b0, NO_RESULT},
        '{1'b0, 8'h01, 1'b0, NO_RESULT},
        '{1'b0, 8'h00, 1'b0, NO_RESULT},
        '{1'b0, 8'h00, 1'b0, NO_RESULT},
        '{1'b0, 8'h03, 1'b0, NO_RESULT},
        '{1'b0, 8'h03, 1'b0, NO_RESULT},
        '{1'b1, 8'h5A, 1'b1, DONE_ONE},
        '{1'b0, 8'h00, 1'b0, NO_RESULT},
        '{1'b0, 8'h09, 1'b0, NO_RESULT},
        '{1'b1, 8'hFF, 1'b1, FALLBACK_RESET}
    };

    usb_interface_descriptor_walker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void walk_restart();
        walk_pos     = '0;
        walk_total   = 9'(BUFFER_BYTES);
        walk_off     = '0;
        walk_len     = '0;
        walk_type    = '0;
        walk_stopped = 1'b0;
        walk_found   = '0;
        for (int i = 0; i < 5; i++) walk_cap[i] = '0;
    endfunction

    function automatic bit walk_step(input bit act, input logic [7:0] b, output result_t r);
        logic [15:0] t;
        logic [8:0]  off;
        logic [8:0]  start;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        if (act) begin
            r.end_of_list = 1'b1;
            if (walk_found > 5'd0) begin
                r.count = walk_found;
            end else begin
                r.record_valid = 1'b1;
                r.number       = FALLBACK_NUMBER;
                r.iclass       = dev_codes.dev_class;
                r.subclass     = dev_codes.dev_subclass;
                r.protocol     = dev_codes.dev_protocol;
                r.count        = 5'd1;
            end
            walk_restart();
            return 1'b1;
        end
        if (walk_pos >= 9'(BUFFER_BYTES)) return 1'b0;
        if (walk_pos == 9'd2) begin
            walk_total = {1'b0, b};
        end else if (walk_pos == 9'd3) begin
            t = {b, walk_total[7:0]};
            walk_total = (t > 16'(BUFFER_BYTES)) ? 9'(BUFFER_BYTES) : t[8:0];
        end
        if (!walk_stopped) begin
            off   = {1'b0, walk_off};
            start = walk_pos - off;
            case (walk_off)
                8'd0: begin
                    walk_len  = b;
                    walk_type = '0;
                    if (b == 8'd0) walk_stopped = 1'b1;
                end
                8'd1: walk_type = b;
                8'd2: walk_cap[0] = b;
                8'd3: walk_cap[1] = b;
                8'd5: walk_cap[2] = b;
                8'd6: walk_cap[3] = b;
                8'd7: begin
                    walk_cap[4] = b;
                    if (walk_type == IFACE_TYPE && walk_len >= MIN_IFACE_LEN &&
                        walk_cap[1] == 8'd0 && start < walk_total &&
                        walk_found < 5'(MAX_INTERFACES)) begin
                        walk_found     = walk_found + 5'd1;
                        r.record_valid = 1'b1;
                        r.number       = walk_cap[0];
                        r.iclass       = walk_cap[2];
                        r.subclass     = walk_cap[3];
                        r.protocol     = walk_cap[4];
                        r.count        = walk_found;
                        hit            = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!walk_stopped) begin
                off = off + 9'd1;
                if (off >= {1'b0, walk_len}) off = '0;
                walk_off = off[7:0];
            end
        end
        walk_pos = walk_pos + 9'd1;
        return hit;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        result_t pred;
        bit      hit;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (records_due.size() == 0) begin
                    $display("%0t unexpected transfer: expected none actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = records_due.pop_front();
                    check_field("record_valid", 32'(want.record_valid), 32'(m_tuser));
                    check_field("if_number", 32'(want.number), 32'(m_tdata[7:0]));
                    check_field("if_class", 32'(want.iclass), 32'(m_tdata[15:8]));
                    check_field("if_subclass", 32'(want.subclass), 32'(m_tdata[23:16]));
                    check_field("if_protocol", 32'(want.protocol), 32'(m_tdata[31:24]));
                    check_field("end_of_list", 32'(want.end_of_list), 32'(m_tlast));
                    check_field("interface_count", 32'(want.count),
                                32'(m_tdata[COUNT_LSB +: COUNT_W]));
                    check_field("pad", 0, 32'(m_tdata[M_TDATA_W-1:COUNT_LSB+COUNT_W]));
                end
            end
            if (s_tvalid && s_tready) begin
                hit = walk_step(s_tuser, s_tdata, pred);
                if (row_typed) records_due.push_back(row_want);
                else if (hit) records_due.push_back(pred);
            end
        end
    end

    initial begin
        int n;
        bit held;
        held = 1'b0;
        wait (aresetn == 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_rx && !held) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(posedge aclk);
                    n++;
                end
                held = 1'b1;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 24);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input bit act, input logic [7:0] data, input bit typed,
                             input result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= act;
        s_tdata   <= data;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (records_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_codes(input dev_codes_t codes);
        logic [IDX_W-1:0] idx [3];
        logic [7:0]       val [3];
        idx = '{REG_DEVICE_CLASS, REG_DEVICE_SUBCLASS, REG_DEVICE_PROTOCOL};
        val = '{codes.dev_class, codes.dev_subclass, codes.dev_protocol};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        dev_codes = codes;
    endtask

    function automatic void push_desc(input int len, input logic [7:0] dtype, input bit alt0);
        frame_q.push_back(len[7:0]);
        if (len > 1) frame_q.push_back(dtype);
        for (int i = 2; i < len; i++) begin
            if (alt0 && i == 3) frame_q.push_back(8'h00);
            else frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void patch_total(input logic [15:0] tl);
        frame_q[2] = tl[7:0];
        frame_q[3] = tl[15:8];
    endfunction

    function automatic void build_config(input bit broken);
        int n;
        int r;
        int sz;
        int sel;
        frame_q.delete();
        push_desc(9, CONFIG_TYPE, 1'b0);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4) push_desc(9, IFACE_TYPE, $urandom_range(0, 3) != 0);
            else if (r == 4) push_desc($urandom_range(8, 12), IFACE_TYPE, 1'b1);
            else if (r == 5) push_desc($urandom_range(3, 7), IFACE_TYPE, 1'b1);
            else if (r < 8) push_desc(7, ENDPOINT_TYPE, 1'b0);
            else if (r == 8) push_desc($urandom_range(2, 12), 8'($urandom_range(0, 255)), 1'b0);
            else push_desc(9, CLASS_TYPE, 1'b0);
        end
        sz  = frame_q.size();
        sel = $urandom_range(0, 9);
        if (sel < 7) patch_total(16'(sz));
        else if (sel < 9) patch_total(16'($urandom_range(0, sz)));
        else patch_total(16'($urandom_range(BUFFER_BYTES + 1, 65535)));
        if (broken) begin
            if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, sz - 1);
                while (frame_q.size() > n) frame_q.pop_back();
            end else begin
                frame_q[$urandom_range(0, sz - 1)] =
                    ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            end
        end
    endfunction

    function automatic void build_oversized();
        frame_q.delete();
        push_desc(9, CONFIG_TYPE, 1'b0);
        for (int i = 0; i < 20; i++) push_desc(9, IFACE_TYPE, 1'b1);
        for (int i = 0; i < 14; i++) push_desc(7, ENDPOINT_TYPE, 1'b0);
        patch_total(16'hFFFF);
    endfunction

    function automatic void build_random_frame();
        int k;
        int n;
        k = $urandom_range(0, 19);
        if (k < 13) begin
            build_config(1'b0);
        end else if (k < 16) begin
            build_config(1'b1);
        end else if (k < 18) begin
            frame_q.delete();
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0) frame_q[0] = 8'h01;
        end else begin
            frame_q.delete();
        end
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) send_item(1'b0, frame_q[i], 1'b0, NO_RESULT);
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    endtask

    initial begin
        dev_codes_t codes;
        int         phase_start;
        walk_restart();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) codes = '{8'hFF, 8'hFF, 8'hFF};
            else if (phase == 1) codes = '{8'h00, 8'h00, 8'h00};
            else codes = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255))};
            write_codes(codes);
            quiet = (phase == NUM_PHASES - 1);
            if (phase == 1) begin
                hold_rx = 1'b1;
                for (int i = 0; i < 6; i++) begin
                    send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
                end
            end
            if (phase == 2) begin
                build_oversized();
                send_frame();
            end
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                build_random_frame();
                send_frame();
            end
            wait_drained();
        end

        repeat (5) @(posedge aclk);
        if (errors == 0 && records_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ usb_interface_descriptor_walker.f @@
src/uidw_pkg.sv
src/uidw_walk.sv
src/usb_interface_descriptor_walker.sv
src/uidw_checker.sv
verif/usb_interface_descriptor_walker_tb.sv
